// ----- design/slwg_pkg.sv -----
// ----------------------------------------------------------------------------
// slwg_pkg - shared definitions for the stepped line window generator
// Field widths, the default window step and the divider handshake type.
// ----------------------------------------------------------------------------
package slwg_pkg;

  // Coordinate and colour widths
  localparam int unsigned CoordW = 8;
  localparam int unsigned ColorW = 16;

  // Numerator of the row offset: offset times row span
  localparam int unsigned NumerW = 2 * CoordW;

  // Default spacing of windows along the stepping axis
  localparam int unsigned StepDef = 5;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic                busy;
    logic                done;
    logic [CoordW-1:0]   quot;
  } div_status_t;

endpackage

// ----- design/stepped_line_window_generator_unit.sv -----
// ----------------------------------------------------------------------------
// stepped_line_window_generator_unit - line to display window sequencer
// Turns one line command into a run of windows spaced STEP along the line.
// ----------------------------------------------------------------------------
// Usage:
//   A line command is taken at a rising edge with start high and busy
//   low. busy stays high until the last window of the line is issued.
//   Each window appears for one cycle with valid_o high; last_window_o marks
//   the final one. The receiver cannot stall, so every window is a transfer.
// Window sequence:
//   A sloped line forms the product offset * row span in S_START and starts
//   the divider, which runs eight steps; the window is registered in S_WAIT
//   once the quotient is ready, and the next window starts only after that.
//   valid_o follows in the next cycle, overlapped with the next window.
//   Vertical lines and single points issue one window per cycle. A line
//   has at most 51 windows with the default step of 5 (64 at a step of 4).
// Reset:
//   Asynchronous, active low. Clears the sequencer and the result strobe;
//   the block is idle and ready afterwards.
// ----------------------------------------------------------------------------
module stepped_line_window_generator_unit #(
  parameter int unsigned STEP = slwg_pkg::StepDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [slwg_pkg::CoordW-1:0]    start_x_i,
  input  logic [slwg_pkg::CoordW-1:0]    start_y_i,
  input  logic [slwg_pkg::CoordW-1:0]    end_x_i,
  input  logic [slwg_pkg::CoordW-1:0]    end_y_i,
  input  logic [slwg_pkg::ColorW-1:0]    line_color_i,
  output logic                           valid_o,
  output logic [slwg_pkg::CoordW-1:0]    win_left_o,
  output logic [slwg_pkg::CoordW-1:0]    win_top_o,
  output logic [slwg_pkg::CoordW-1:0]    win_right_o,
  output logic [slwg_pkg::CoordW-1:0]    win_bottom_o,
  output logic [slwg_pkg::ColorW-1:0]    pixel_color_o,
  output logic                           last_window_o
);

  localparam int unsigned W = slwg_pkg::CoordW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_WAIT
  } state_e;

  state_e                        state_q;
  logic [W-1:0]                  x0_q, y0_q;
  logic [slwg_pkg::ColorW-1:0]   color_q;
  logic [W-1:0]                  dx_abs_q, dy_abs_q, span_q;
  logic                          dx_neg_q, dy_neg_q, vert_q, point_q;
  logic [W-1:0]                  off_q;
  logic                          valid_q;

  logic [W:0]                    dx_in, dy_in;
  logic [W-1:0]                  dx_abs_in, dy_abs_in;
  logic                          accept;
  logic                          div_start;
  logic [slwg_pkg::NumerW-1:0]   numer;
  slwg_pkg::div_status_t         div_st;
  logic                          emit;
  logic [W-1:0]                  oy_mag;
  logic [W-1:0]                  left, top, right, bottom;
  logic                          last;
  logic [W:0]                    next_off;

  // Command transfer and signed spans
  assign accept    = start && (state_q == S_IDLE);
  assign dx_in     = {1'b0, end_x_i} - {1'b0, start_x_i};
  assign dy_in     = {1'b0, end_y_i} - {1'b0, start_y_i};
  assign dx_abs_in = dx_in[W] ? W'(-dx_in) : dx_in[W-1:0];
  assign dy_abs_in = dy_in[W] ? W'(-dy_in) : dy_in[W-1:0];

  // Row offset numerator feeds the divider straight from the multiplier
  assign numer     = off_q * dy_abs_q;
  assign div_start = (state_q == S_START) && !vert_q && !point_q;

  slwg_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .numer_i  (numer),
    .denom_i  (dx_abs_q),
    .status_o (div_st)
  );

  // Window corners for the current offset
  always_comb begin
    emit     = ((state_q == S_START) && (vert_q || point_q)) ||
               ((state_q == S_WAIT) && div_st.done);
    oy_mag   = vert_q ? off_q : div_st.quot;
    next_off = {1'b0, off_q} + (W + 1)'(STEP);
    last     = point_q || (next_off >= {1'b0, span_q});
    if (vert_q || point_q) begin
      left = x0_q;
    end else begin
      left = dx_neg_q ? x0_q - off_q : x0_q + off_q;
    end
    if (point_q) begin
      top    = y0_q;
      right  = x0_q;
      bottom = y0_q;
    end else begin
      top    = dy_neg_q ? y0_q - oy_mag : y0_q + oy_mag;
      right  = left + W'(STEP);
      bottom = top + W'(STEP);
    end
  end

  // Sequencer and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      valid_q <= emit;
      case (state_q)
        S_IDLE: begin
          if (accept) state_q <= S_START;
        end
        S_START: begin
          if (emit) begin
            if (last) state_q <= S_IDLE;
          end else begin
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (emit) state_q <= last ? S_IDLE : S_START;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Command capture, offset advance and result fields
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x0_q     <= start_x_i;
      y0_q     <= start_y_i;
      color_q  <= line_color_i;
      dx_abs_q <= dx_abs_in;
      dy_abs_q <= dy_abs_in;
      dx_neg_q <= dx_in[W];
      dy_neg_q <= dy_in[W];
      vert_q   <= (dx_abs_in == '0) && (dy_abs_in != '0);
      point_q  <= (dx_abs_in == '0) && (dy_abs_in == '0);
      span_q   <= (dx_abs_in != '0) ? dx_abs_in : dy_abs_in;
      off_q    <= '0;
    end else if (emit) begin
      off_q <= next_off[W-1:0];
    end
    if (emit) begin
      win_left_o    <= left;
      win_top_o     <= top;
      win_right_o   <= right;
      win_bottom_o  <= bottom;
      pixel_color_o <= color_q;
      last_window_o <= last;
    end
  end

  assign busy    = (state_q != S_IDLE);
  assign valid_o = valid_q;

`ifndef ASSERT_OFF
  // A window that is not the last one leaves the block busy
  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_window_o |-> busy)
    else $error("block idle before last window");

  // The last window is never followed at once by another
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_window_o |=> !valid_o)
    else $error("window issued right after last window");

  // A taken command makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("command taken without going busy");

  // The divider only runs for sloped lines while waiting on it
  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.busy |-> (state_q == S_WAIT) && !vert_q && !point_q)
    else $error("divider running outside its wait state");
`endif

endmodule

// ----- design/slwg_div.sv -----
// ----------------------------------------------------------------------------
// slwg_div - iterative restoring divider
// Divides a 16-bit numerator by an 8-bit divisor, one quotient bit a cycle.
// The quotient is known to fit in 8 bits, so eight steps suffice.
// ----------------------------------------------------------------------------
module slwg_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [slwg_pkg::NumerW-1:0]    numer_i,
  input  logic [slwg_pkg::CoordW-1:0]    denom_i,
  output slwg_pkg::div_status_t          status_o
);

  localparam int unsigned W    = slwg_pkg::CoordW;
  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    quo_q, quo_d;
  logic [W-1:0]    den_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [W:0]      trial;
  logic            ge;

  // Trial subtract: shift the next numerator bit into the remainder
  always_comb begin
    trial = {rem_q, quo_q[W-1]};
    ge    = (trial >= {1'b0, den_q});
    rem_d = ge ? W'(trial - {1'b0, den_q}) : trial[W-1:0];
    quo_d = {quo_q[W-2:0], ge};
  end

  // Load on start, then iterate until the count runs out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= numer_i[2*W-1:W];
      quo_q <= numer_i[W-1:0];
      den_q <= denom_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign status_o.quot = quo_q;

`ifndef ASSERT_OFF
  // Remainder stays below the divisor while iterating
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !$past(start_i) |-> rem_q < den_q)
    else $error("divider remainder not below divisor");

  // Completion is a single-cycle pulse that ends the run
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q ##1 !done_q)
    else $error("divider done not a single pulse");

  // A start always leads to a busy run
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q)
    else $error("divider did not start");
`endif

endmodule
